// ===== rtl/assert_macros.svh =====
// assertion macros shared by checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert that a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
// assert that a implies b in the same cycle
`define ASSERT_SAME(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`endif

// ===== rtl/ufu_pkg.sv =====
// shared constants and types of the update receiver
`default_nettype none
package ufu_pkg;
  localparam int unsigned PacketDepth = 256;
  localparam int unsigned RunLength = 16;

  localparam logic [1:0] ACT_BYTE = 2'd0;
  localparam logic [1:0] ACT_TICK = 2'd1;
  localparam logic [1:0] ACT_ERASE = 2'd2;
  localparam logic [1:0] ACT_SUM = 2'd3;

  localparam logic [2:0] KIND_RESP = 3'd0;
  localparam logic [2:0] KIND_WRITE = 3'd1;
  localparam logic [2:0] KIND_ERASE = 3'd2;
  localparam logic [2:0] KIND_SUMREQ = 3'd3;
  localparam logic [2:0] KIND_END = 3'd4;

  localparam logic [2:0] PH_DETECT = 3'd0;
  localparam logic [2:0] PH_SYNC = 3'd1;
  localparam logic [2:0] PH_HANDSHAKE = 3'd2;
  localparam logic [2:0] PH_ERASING = 3'd3;
  localparam logic [2:0] PH_RECEIVE = 3'd4;
  localparam logic [2:0] PH_VERIFY = 3'd5;
  localparam logic [2:0] PH_WAITEND = 3'd6;
  localparam logic [2:0] PH_ENDED = 3'd7;

  localparam logic [7:0] B_SYNC = 8'h7F;
  localparam logic [7:0] B_HS = 8'h55;
  localparam logic [7:0] B_DATAEND = 8'hAE;
  localparam logic [7:0] B_END = 8'hAF;
  localparam logic [7:0] R_SYNC = 8'hA0;
  localparam logic [7:0] R_HS = 8'hA1;
  localparam logic [7:0] R_ERASE_OK = 8'hA2;
  localparam logic [7:0] R_SAVED = 8'hA3;
  localparam logic [7:0] R_DATAEND = 8'hA4;
  localparam logic [7:0] R_SUM_OK = 8'hA5;
  localparam logic [7:0] R_DONE = 8'hA6;
  localparam logic [7:0] R_ERASE_BAD = 8'hE1;
  localparam logic [7:0] R_CSUM_BAD = 8'hE4;
  localparam logic [7:0] R_TOO_LONG = 8'hE5;
  localparam logic [7:0] R_SUM_BAD = 8'hE7;
  localparam logic [7:0] R_TIMEOUT = 8'hEF;

  localparam logic [2:0] REG_BASE = 3'd0;
  localparam logic [2:0] REG_DETECT = 3'd1;
  localparam logic [2:0] REG_SYNC = 3'd2;
  localparam logic [2:0] REG_HS = 3'd3;
  localparam logic [2:0] REG_XFER = 3'd4;

  localparam logic [19:0] BASE_RESET = 20'h08000;

  // classified item, front to back
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
    logic       erase_ok;
    logic [7:0] flash_sum;
  } item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  response;
    logic [19:0] write_addr;
    logic [63:0] write_data;
    logic [19:0] sum_length;
    logic        reboot;
    logic        last;
  } result_t;
endpackage
`default_nettype wire

// ===== rtl/ufu_ram.sv =====
// generic single-port write, registered-read ram
`default_nettype none
module ufu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/ufu_front.sv =====
// input queue: two-entry item fifo
`default_nettype none
module ufu_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire ufu_pkg::item_t din,
  output logic                full,
  input  wire logic           pop,
  output ufu_pkg::item_t      dout,
  output logic                avail
);
  ufu_pkg::item_t q_r [2];
  logic [1:0] cnt_r;
  logic       rd_r, wr_r;
  logic       do_push, do_pop;

  assign full = (cnt_r == 2'd2);
  assign avail = (cnt_r != 2'd0);
  assign dout = q_r[rd_r];
  assign do_push = push && !full;
  assign do_pop = pop && avail;

  always_ff @(posedge clk) begin
    if (do_push) q_r[wr_r] <= din;
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      if (do_push) wr_r <= !wr_r;
      if (do_pop) rd_r <= !rd_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/ufu_back.sv =====
// protocol engine: phases, packet store, repacking, result register
`default_nettype none
module ufu_back #(
  parameter int unsigned PacketDepth = ufu_pkg::PacketDepth,
  parameter int unsigned RunLength = ufu_pkg::RunLength
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             item_avail,
  input  wire ufu_pkg::item_t   item,
  output logic                  item_pop,
  input  wire logic [19:0]      flash_base,
  input  wire logic [15:0]      win_detect,
  input  wire logic [15:0]      win_sync,
  input  wire logic [15:0]      win_hs,
  input  wire logic [15:0]      win_xfer,
  output ufu_pkg::result_t      res,
  output logic                  res_valid,
  input  wire logic             res_pop
);
  localparam int unsigned AW = $clog2(PacketDepth);
  localparam int unsigned CW = $clog2(PacketDepth + 2);
  localparam logic [CW-1:0] DepthC = CW'(PacketDepth);
  localparam logic [3:0] RunM1 = 4'(RunLength - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM = 3'd1;
  localparam logic [2:0] S_PACK = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_FIN = 3'd4;

  logic [2:0]  st_r, st_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  run_r, run_nxt;
  logic [15:0] tl_r, tl_nxt;
  logic [7:0]  plen_r, plen_nxt;
  logic [CW-1:0] pcnt_r, pcnt_nxt;
  logic [19:0] icnt_r, icnt_nxt;
  logic [63:0] tail_r, tail_nxt;
  logic [2:0]  tlen_r, tlen_nxt;
  logic [7:0]  isum_r, isum_nxt;
  logic [15:0] pair_r, pair_nxt;
  logic [1:0]  pcnt2_r, pcnt2_nxt;
  // packet walk
  logic [8:0]  idx_r, idx_nxt;     // byte index being accumulated
  logic        rv_r, rv_nxt;       // ram read outstanding
  logic [8:0]  ridx_r, ridx_nxt;   // index of data in rdata
  logic [7:0]  csum_r, csum_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  afill_r, afill_nxt;
  logic [19:0] aoff_r, aoff_nxt;
  // pending result slots
  ufu_pkg::result_t q_r [2];
  ufu_pkg::result_t q_nxt [2];
  logic [1:0]  qn_r, qn_nxt;
  ufu_pkg::result_t out_r, out_nxt;
  logic        ov_r, ov_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    rdata;

  ufu_ram #(.Width(8), .Depth(PacketDepth)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(item.rx_byte),
    .raddr(raddr), .rdata(rdata)
  );

  assign res = out_r;
  assign res_valid = ov_r;

  function automatic logic [15:0] win(input logic [15:0] w);
    win = (w == 16'd0) ? 16'd1 : w;
  endfunction

  function automatic ufu_pkg::result_t mk(input logic [2:0] k, input logic [7:0] r,
                                          input logic [19:0] a, input logic [63:0] d,
                                          input logic [19:0] l, input logic rb);
    ufu_pkg::result_t t;
    t.kind = k; t.response = r; t.write_addr = a; t.write_data = d;
    t.sum_length = l; t.reboot = rb; t.last = 1'b0;
    mk = t;
  endfunction

  logic out_free;
  assign out_free = !ov_r || res_pop;

  always_comb begin
    logic [63:0] keep;
    logic [7:0]  b;
    logic [2:0]  sh;
    st_nxt = st_r; phase_nxt = phase_r; run_nxt = run_r; tl_nxt = tl_r;
    plen_nxt = plen_r; pcnt_nxt = pcnt_r; icnt_nxt = icnt_r; tail_nxt = tail_r;
    tlen_nxt = tlen_r; isum_nxt = isum_r; pair_nxt = pair_r; pcnt2_nxt = pcnt2_r;
    idx_nxt = idx_r; rv_nxt = 1'b0; ridx_nxt = ridx_r;
    csum_nxt = csum_r; acc_nxt = acc_r; afill_nxt = afill_r; aoff_nxt = aoff_r;
    q_nxt = q_r; qn_nxt = qn_r; out_nxt = out_r; ov_nxt = ov_r;
    item_pop = 1'b0; we = 1'b0;
    waddr = pcnt_r[AW-1:0] - AW'(1);
    raddr = idx_r[AW-1:0];
    b = item.rx_byte;
    keep = 64'd0;
    sh = 3'd0;
    if (res_pop && ov_r) ov_nxt = 1'b0;

    case (st_r)
      S_IDLE: begin
        // move queued results into the output register first
        if (qn_r != 2'd0) begin
          if (out_free) begin
            out_nxt = q_r[0];
            ov_nxt = 1'b1;
            q_nxt[0] = q_r[1];
            qn_nxt = qn_r - 2'd1;
          end
        end else if (item_avail) begin
          item_pop = 1'b1;
          if (phase_r != ufu_pkg::PH_ENDED) begin
            case (item.action)
              ufu_pkg::ACT_BYTE: begin
                case (phase_r)
                  ufu_pkg::PH_DETECT: if (b == ufu_pkg::B_SYNC) begin
                    phase_nxt = ufu_pkg::PH_SYNC; tl_nxt = win(win_sync); run_nxt = 4'd1;
                  end
                  ufu_pkg::PH_SYNC: begin
                    if (b != ufu_pkg::B_SYNC) begin
                      q_nxt[0] = mk(ufu_pkg::KIND_END, 8'd0, 20'd0, 64'd0, 20'd0, 1'b0);
                      q_nxt[0].last = 1'b1; qn_nxt = 2'd1; phase_nxt = ufu_pkg::PH_ENDED;
                    end else if (run_r >= RunM1) begin
                      q_nxt[0] = mk(ufu_pkg::KIND_RESP, ufu_pkg::R_SYNC, 20'd0, 64'd0,
                                    20'd0, 1'b0);
                      q_nxt[0].last = 1'b1; qn_nxt = 2'd1;
                      phase_nxt = ufu_pkg::PH_HANDSHAKE; tl_nxt = win(win_hs);
                      run_nxt = 4'd0;
                    end else run_nxt = run_r + 4'd1;
                  end
                  ufu_pkg::PH_HANDSHAKE: begin
                    if (b == ufu_pkg::B_HS) begin
                      if (run_r >= RunM1) begin
                        q_nxt[0] = mk(ufu_pkg::KIND_RESP, ufu_pkg::R_HS, 20'd0, 64'd0,
                                      20'd0, 1'b0);
                        q_nxt[1] = mk(ufu_pkg::KIND_ERASE, 8'd0, 20'd0, 64'd0, 20'd0, 1'b0);
                        q_nxt[1].last = 1'b1; qn_nxt = 2'd2;
                        phase_nxt = ufu_pkg::PH_ERASING; run_nxt = 4'd0;
                      end else run_nxt = run_r + 4'd1;
                    end else if (b != ufu_pkg::B_SYNC) begin
                      q_nxt[0] = mk(ufu_pkg::KIND_END, 8'd0, 20'd0, 64'd0, 20'd0, 1'b0);
                      q_nxt[0].last = 1'b1; qn_nxt = 2'd1; phase_nxt = ufu_pkg::PH_ENDED;
                    end
                  end
                  ufu_pkg::PH_RECEIVE: begin
                    if (b == ufu_pkg::B_HS && pcnt_r == '0 && icnt_r == 20'd0) begin
                      // leading handshake byte skipped
                    end else if (pcnt_r == '0) begin
                      plen_nxt = b; pcnt_nxt = CW'(1);
                    end else if (pcnt_r - CW'(1) >= DepthC) begin
                      q_nxt[0] = mk(ufu_pkg::KIND_RESP, ufu_pkg::R_TOO_LONG, 20'd0, 64'd0,
                                    20'd0, 1'b0);
                      q_nxt[1] = mk(ufu_pkg::KIND_END, 8'd0, 20'd0, 64'd0, 20'd0, 1'b1);
                      q_nxt[1].last = 1'b1; qn_nxt = 2'd2; phase_nxt = ufu_pkg::PH_ENDED;
                    end else begin
                      we = 1'b1;
                      pcnt_nxt = pcnt_r + CW'(1);
                      if (pcnt_r == CW'(1) && plen_r == ufu_pkg::B_DATAEND &&
                          b == ufu_pkg::B_DATAEND) begin
                        keep = (64'd1 << {tlen_r, 3'b000}) - 64'd1;
                        if (tlen_r != 3'd0) begin
                          q_nxt[0] = mk(ufu_pkg::KIND_WRITE, 8'd0,
                                        flash_base + icnt_r - {17'd0, tlen_r},
                                        (tail_r & keep) | ~keep, 20'd0, 1'b0);
                          q_nxt[1] = mk(ufu_pkg::KIND_RESP, ufu_pkg::R_DATAEND, 20'd0,
                                        64'd0, 20'd0, 1'b0);
                          q_nxt[1].last = 1'b1; qn_nxt = 2'd2;
                        end else begin
                          q_nxt[0] = mk(ufu_pkg::KIND_RESP, ufu_pkg::R_DATAEND, 20'd0,
                                        64'd0, 20'd0, 1'b0);
                          q_nxt[0].last = 1'b1; qn_nxt = 2'd1;
                        end
                        phase_nxt = ufu_pkg::PH_VERIFY; tl_nxt = win(win_xfer);
                        pcnt_nxt = '0; plen_nxt = 8'd0; pcnt2_nxt = 2'd0;
                        pair_nxt = 16'd0;
                      end else if (pcnt_r + CW'(1) == CW'(plen_r) + CW'(2)) begin
                        // packet complete: walk the store
                        st_nxt = S_SUM; idx_nxt = 9'd0; csum_nxt = 8'd0;
                        rv_nxt = 1'b0;
                      end
                    end
                  end
                  ufu_pkg::PH_VERIFY: if (pcnt2_r < 2'd2) begin
                    pair_nxt = {pair_r[7:0], b};
                    pcnt2_nxt = pcnt2_r + 2'd1;
                    if (pcnt2_r == 2'd1) begin
                      q_nxt[0] = mk(ufu_pkg::KIND_SUMREQ, 8'd0, 20'd0, 64'd0, icnt_r, 1'b0);
                      q_nxt[0].last = 1'b1; qn_nxt = 2'd1;
                    end
                  end
                  ufu_pkg::PH_WAITEND: begin
                    pair_nxt = {pair_r[7:0], b};
                    pcnt2_nxt = pcnt2_r + 2'd1;
                    if (pcnt2_r >= 2'd1) begin
                      if ({pair_r[7:0], b} == {ufu_pkg::B_END, ufu_pkg::B_END}) begin
                        q_nxt[0] = mk(ufu_pkg::KIND_RESP, ufu_pkg::R_DONE, 20'd0, 64'd0,
                                      20'd0, 1'b0);
                        q_nxt[1] = mk(ufu_pkg::KIND_END, 8'd0, 20'd0, 64'd0, 20'd0, 1'b1);
                        q_nxt[1].last = 1'b1; qn_nxt = 2'd2;
                        phase_nxt = ufu_pkg::PH_ENDED;
                      end
                      pcnt2_nxt = 2'd0; pair_nxt = 16'd0;
                    end
                  end
                  default: ;
                endcase
              end
              ufu_pkg::ACT_TICK: if (phase_r != ufu_pkg::PH_ERASING) begin
                if (tl_r <= 16'd1) begin
                  q_nxt[0] = mk(ufu_pkg::KIND_RESP, ufu_pkg::R_TIMEOUT, 20'd0, 64'd0,
                                20'd0, 1'b0);
                  q_nxt[1] = mk(ufu_pkg::KIND_END, 8'd0, 20'd0, 64'd0, 20'd0,
                                phase_r > ufu_pkg::PH_HANDSHAKE);
                  q_nxt[1].last = 1'b1; qn_nxt = 2'd2; phase_nxt = ufu_pkg::PH_ENDED;
                end else tl_nxt = tl_r - 16'd1;
              end
              ufu_pkg::ACT_ERASE: if (phase_r == ufu_pkg::PH_ERASING) begin
                if (!item.erase_ok) begin
                  q_nxt[0] = mk(ufu_pkg::KIND_RESP, ufu_pkg::R_ERASE_BAD, 20'd0, 64'd0,
                                20'd0, 1'b0);
                  q_nxt[1] = mk(ufu_pkg::KIND_END, 8'd0, 20'd0, 64'd0, 20'd0, 1'b1);
                  q_nxt[1].last = 1'b1; qn_nxt = 2'd2; phase_nxt = ufu_pkg::PH_ENDED;
                end else begin
                  q_nxt[0] = mk(ufu_pkg::KIND_RESP, ufu_pkg::R_ERASE_OK, 20'd0, 64'd0,
                                20'd0, 1'b0);
                  q_nxt[0].last = 1'b1; qn_nxt = 2'd1;
                  phase_nxt = ufu_pkg::PH_RECEIVE; tl_nxt = win(win_xfer);
                  pcnt_nxt = '0; plen_nxt = 8'd0; icnt_nxt = 20'd0; tlen_nxt = 3'd0;
                  tail_nxt = 64'd0; isum_nxt = 8'd0; run_nxt = 4'd0;
                end
              end
              default: if (phase_r == ufu_pkg::PH_VERIFY && pcnt2_r == 2'd2) begin
                if (pair_r != icnt_r[15:0] || item.flash_sum != isum_r) begin
                  q_nxt[0] = mk(ufu_pkg::KIND_RESP, ufu_pkg::R_SUM_BAD, 20'd0, 64'd0,
                                20'd0, 1'b0);
                end else begin
                  q_nxt[0] = mk(ufu_pkg::KIND_RESP, ufu_pkg::R_SUM_OK, 20'd0, 64'd0,
                                20'd0, 1'b0);
                  phase_nxt = ufu_pkg::PH_WAITEND; tl_nxt = win(win_xfer);
                end
                q_nxt[0].last = 1'b1; qn_nxt = 2'd1;
                pcnt2_nxt = 2'd0; pair_nxt = 16'd0;
              end
            endcase
          end
        end
      end
      S_SUM: begin
        // checksum pass: one byte a cycle over data bytes and checksum byte
        raddr = idx_r[AW-1:0];
        if (rv_r) begin
          if (ridx_r == {1'b0, plen_r}) begin
            if (rdata != csum_r) begin
              q_nxt[0] = mk(ufu_pkg::KIND_RESP, ufu_pkg::R_CSUM_BAD, 20'd0, 64'd0,
                            20'd0, 1'b0);
              q_nxt[1] = mk(ufu_pkg::KIND_END, 8'd0, 20'd0, 64'd0, 20'd0, 1'b1);
              q_nxt[1].last = 1'b1; qn_nxt = 2'd2; phase_nxt = ufu_pkg::PH_ENDED;
              st_nxt = S_IDLE;
            end else begin
              isum_nxt = isum_r + csum_r;
              st_nxt = S_PACK; idx_nxt = 9'd0;
              acc_nxt = tail_r; afill_nxt = {1'b0, tlen_r};
              aoff_nxt = icnt_r - {17'd0, tlen_r};
            end
          end else csum_nxt = csum_r + rdata;
        end
        if (st_nxt == S_SUM && idx_r <= {1'b0, plen_r}) begin
          rv_nxt = 1'b1; ridx_nxt = idx_r; idx_nxt = idx_r + 9'd1;
        end
      end
      S_PACK: begin
        // repack data bytes into double words, emitting each as it fills
        raddr = idx_r[AW-1:0];
        if (afill_r == 4'd8) begin
          if (out_free) begin
            out_nxt = mk(ufu_pkg::KIND_WRITE, 8'd0, flash_base + aoff_r, acc_r,
                         20'd0, 1'b0);
            ov_nxt = 1'b1;
            afill_nxt = 4'd0; acc_nxt = 64'd0; aoff_nxt = aoff_r + 20'd8;
          end
        end else if (rv_r) begin
          sh = afill_r[2:0];
          acc_nxt = acc_r & ~(64'hFF << {sh, 3'b000});
          acc_nxt = acc_nxt | ({56'd0, rdata} << {sh, 3'b000});
          afill_nxt = afill_r + 4'd1;
        end else if (idx_r < {1'b0, plen_r}) begin
          rv_nxt = 1'b1; idx_nxt = idx_r + 9'd1;
        end else st_nxt = S_FIN;
      end
      S_FIN: begin
        tail_nxt = acc_r; tlen_nxt = afill_r[2:0];
        icnt_nxt = icnt_r + {12'd0, plen_r};
        plen_nxt = 8'd0; pcnt_nxt = '0; tl_nxt = win(win_xfer);
        q_nxt[0] = mk(ufu_pkg::KIND_RESP, ufu_pkg::R_SAVED, 20'd0, 64'd0, 20'd0, 1'b0);
        q_nxt[0].last = 1'b1; qn_nxt = 2'd1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
    // clear the accumulator when the data ends on a double-word boundary
    if (st_r == S_PACK && st_nxt == S_FIN && afill_r == 4'd0) acc_nxt = 64'd0;
    if (st_r == S_EMIT) st_nxt = S_IDLE;
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt; out_r <= out_nxt; plen_r <= plen_nxt; tail_r <= tail_nxt;
    pair_r <= pair_nxt; idx_r <= idx_nxt; ridx_r <= ridx_nxt; csum_r <= csum_nxt;
    acc_r <= acc_nxt; afill_r <= afill_nxt; aoff_r <= aoff_nxt;
    isum_r <= isum_nxt; icnt_r <= icnt_nxt; tlen_r <= tlen_nxt;
    if (!rst_n) begin
      st_r <= S_IDLE; phase_r <= ufu_pkg::PH_DETECT; run_r <= 4'd0;
      tl_r <= win_detect; pcnt_r <= '0; pcnt2_r <= 2'd0; qn_r <= 2'd0;
      ov_r <= 1'b0; rv_r <= 1'b0;
      plen_r <= 8'd0; icnt_r <= 20'd0; tail_r <= 64'd0; tlen_r <= 3'd0;
      isum_r <= 8'd0; pair_r <= 16'd0;
    end else begin
      st_r <= st_nxt; phase_r <= phase_nxt; run_r <= run_nxt; tl_r <= tl_nxt;
      pcnt_r <= pcnt_nxt; pcnt2_r <= pcnt2_nxt; qn_r <= qn_nxt; ov_r <= ov_nxt;
      rv_r <= rv_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/uart_firmware_update_receiver_core.sv =====
// Firmware update receiver: UART protocol engine for in-application updates.
// Input channel (push/full) carries items: received bytes, millisecond ticks,
// erase status and flash read-back sum, tagged by in_action.
// Result channel (empty/pop) carries response bytes, flash double-word
// writes, erase and sum requests and the session end; out_last marks the
// final result of an item.
// Items enter a two-entry queue, so the sender may push while the engine works.
// The results of an item reach the output register one a cycle while pop is
// high; the next item is taken only once all have left the result slots.
// A packet end makes a checksum pass over the data and checksum bytes and, if
// the sum matches, a repack pass through the store's one read port that emits
// each double-word write as it fills; no item is taken until the passes end.
// Results leave through a one-entry output register; if pop stays low the
// engine holds and the input queue fills, raising full.
// Reset (rst_n low, synchronous) returns to waiting for the first sync byte
// with registers at defaults; the packet store needs no clearing.
// The APB port writes the five window and base registers, pready always high.
`default_nettype none
module uart_firmware_update_receiver_core #(
  parameter int unsigned PacketDepth = ufu_pkg::PacketDepth,
  parameter int unsigned RunLength = ufu_pkg::RunLength
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  in_action,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        in_erase_ok,
  input  wire logic [7:0]  in_flash_sum,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_response,
  output logic [19:0]      out_write_addr,
  output logic [63:0]      out_write_data,
  output logic [19:0]      out_sum_length,
  output logic             out_reboot,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [19:0] base_r;
  logic [15:0] det_r, syn_r, hs_r, xfer_r;
  logic [2:0]  ridx;
  ufu_pkg::item_t din, item;
  ufu_pkg::result_t res;
  logic item_avail, item_pop, res_valid;

  assign pready = 1'b1;
  assign ridx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= ufu_pkg::BASE_RESET; det_r <= 16'd100; syn_r <= 16'd1000;
      hs_r <= 16'd3000; xfer_r <= 16'd10000;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        ufu_pkg::REG_BASE: base_r <= pwdata[19:0];
        ufu_pkg::REG_DETECT: det_r <= pwdata[15:0];
        ufu_pkg::REG_SYNC: syn_r <= pwdata[15:0];
        ufu_pkg::REG_HS: hs_r <= pwdata[15:0];
        ufu_pkg::REG_XFER: xfer_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      ufu_pkg::REG_BASE: prdata = {12'd0, base_r};
      ufu_pkg::REG_DETECT: prdata = {16'd0, det_r};
      ufu_pkg::REG_SYNC: prdata = {16'd0, syn_r};
      ufu_pkg::REG_HS: prdata = {16'd0, hs_r};
      ufu_pkg::REG_XFER: prdata = {16'd0, xfer_r};
      default: prdata = 32'd0;
    endcase
  end

  assign din.action = in_action;
  assign din.rx_byte = in_rx_byte;
  assign din.erase_ok = in_erase_ok;
  assign din.flash_sum = in_flash_sum;

  ufu_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .din(din), .full(full),
    .pop(item_pop), .dout(item), .avail(item_avail)
  );

  ufu_back #(.PacketDepth(PacketDepth), .RunLength(RunLength)) u_back (
    .clk(clk), .rst_n(rst_n), .item_avail(item_avail), .item(item),
    .item_pop(item_pop), .flash_base(base_r), .win_detect(det_r),
    .win_sync(syn_r), .win_hs(hs_r), .win_xfer(xfer_r),
    .res(res), .res_valid(res_valid), .res_pop(pop)
  );

  assign empty = !res_valid;
  assign out_kind = res.kind;
  assign out_response = res.response;
  assign out_write_addr = res.write_addr;
  assign out_write_data = res.write_data;
  assign out_sum_length = res.sum_length;
  assign out_reboot = res.reboot;
  assign out_last = res.last;
endmodule
`default_nettype wire

// ===== rtl/ufu_checker.sv =====
// port-level checker for the update receiver, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module ufu_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [2:0] out_kind,
  input wire logic       out_reboot,
  input wire logic       pready
);
  `ASSERT_SAME(a_ready, clk, rst_n, 1'b1, pready)
  `ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty)
  `ASSERT_SAME(a_kind, clk, rst_n, !empty, out_kind <= ufu_pkg::KIND_END)
  `ASSERT_SAME(a_reboot, clk, rst_n, !empty && out_kind != ufu_pkg::KIND_END, !out_reboot)
endmodule

bind uart_firmware_update_receiver_core ufu_checker u_chk (
  .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop), .out_kind(out_kind),
  .out_reboot(out_reboot), .pready(pready)
);
`default_nettype wire
